FILE: hw/rtl/mpdc_pkg.sv
// ----------------------------------------------------------------------------
// Manchester pulse decoder package
// Shared types and constants of the pulse decoder with CRC-16 packet check.
// ----------------------------------------------------------------------------
package mpdc_pkg;

    localparam int MAX_BYTES = 564;
    localparam int CNT_W     = 10;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int ODEPTH    = 4;
    localparam int OAW       = $clog2(ODEPTH);

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h8005;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_WIDTH = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_BAD_CRC   = 3'd4;

    typedef enum logic [1:0] {
        CLS_SHORT,
        CLS_LONG,
        CLS_BAD
    } cls_t;

    typedef struct packed {
        cls_t cls;
        logic last;
    } item_t;

    typedef struct packed {
        logic             level;
        logic [3:0]       phase;
        logic             sync;
        logic             held;
        logic [7:0]       shift;
        logic [CNT_W-1:0] count;
        logic [7:0]       r0;
        logic [7:0]       r1;
        logic [7:0]       r2;
        logic [2:0]       err;
    } dec_state_t;

    localparam dec_state_t DEC_RESET = '{level: 1'b1, default: '0};

    typedef struct packed {
        dec_state_t       st;
        logic             emit;
        logic [7:0]       ebyte;
        logic [2:0]       estat;
        logic [CNT_W-1:0] ecount;
        logic             crc_upd;
        logic [7:0]       crc_in;
    } hb_step_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [2:0]       status;
        logic [CNT_W-1:0] total;
        logic             run_end;
    } out_word_t;

endpackage

FILE: hw/rtl/mpdc_front.sv
// ----------------------------------------------------------------------------
// Pulse classifier
// Holds the window registers and sorts each duration into short, long or bad.
// ----------------------------------------------------------------------------
module mpdc_front import mpdc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    output logic                 push_valid,
    input  logic                 push_ready,
    output item_t                push_item
);

    logic [7:0] short_min_reg;
    logic [7:0] short_limit_reg;
    logic [7:0] long_min_reg;
    logic [7:0] long_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_min_reg   <= 8'd60;
            short_limit_reg <= 8'd115;
            long_min_reg    <= 8'd140;
            long_limit_reg  <= 8'd200;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SHORT_MIN:   short_min_reg   <= cfg_wdata;
                REG_SHORT_LIMIT: short_limit_reg <= cfg_wdata;
                REG_LONG_MIN:    long_min_reg    <= cfg_wdata;
                REG_LONG_LIMIT:  long_limit_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        push_item.last = s_tlast;
        priority if (s_tdata >= short_min_reg && s_tdata < short_limit_reg) begin
            push_item.cls = CLS_SHORT;
        end else if (s_tdata >= long_min_reg && s_tdata < long_limit_reg) begin
            push_item.cls = CLS_LONG;
        end else begin
            push_item.cls = CLS_BAD;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

FILE: hw/rtl/mpdc_queue.sv
// ----------------------------------------------------------------------------
// Item queue
// Short queue of classified pulses between the classifier and the decoder.
// ----------------------------------------------------------------------------
module mpdc_queue import mpdc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t          mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != (QAW+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/mpdc_back.sv
// ----------------------------------------------------------------------------
// Manchester decoder back end
// Turns classified pulses into half-bits, bytes, CRC state and status words.
// ----------------------------------------------------------------------------
module mpdc_back import mpdc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  d;
        logic        fb;
        c = c_in;
        d = b;
        for (int k = 0; k < 8; k++) begin
            fb = c[15] ^ d[7];
            c  = {c[14:0], 1'b0};
            d  = {d[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic hb_step_t take_hb(hb_step_t x_in, logic h);
        hb_step_t x;
        logic     bit_v;
        x = x_in;
        bit_v = 1'b0;
        if (x.st.err == ST_OK) begin
            if (!x.st.sync) begin
                x.st.sync = 1'b1;
            end else if (x.st.phase[0]) begin
                x.st.held = h;
            end else begin
                bit_v = (x.st.held != h) ? x.st.held : 1'b0;
                x.st.shift = {x.st.shift[6:0], bit_v};
                if (x.st.phase == 4'd0) begin
                    x.crc_upd  = (x.st.count >= CNT_W'(3));
                    x.crc_in   = x.st.r2;
                    x.st.r2    = x.st.r1;
                    x.st.r1    = x.st.r0;
                    x.st.r0    = x.st.shift;
                    x.st.count = x.st.count + 1'b1;
                    if (x.st.count >= CNT_W'(MAX_BYTES)) begin
                        x.st.err = ST_OVERFLOW;
                    end
                    x.emit     = 1'b1;
                    x.ebyte    = x.st.shift;
                    x.estat    = x.st.err;
                    x.ecount   = x.st.count;
                    x.st.shift = '0;
                end
            end
            x.st.phase = x.st.phase + 1'b1;
        end
        return x;
    endfunction

    dec_state_t  st_reg;
    dec_state_t  st_new;
    logic [15:0] crc_reg;
    logic [15:0] crc_new;
    logic [15:0] crc_mid;
    logic [15:0] crc_chk;
    hb_step_t    x;
    logic [2:0]  eop_status;
    out_word_t   byte_word;
    out_word_t   stat_word;
    logic        do_step;

    out_word_t    omem [ODEPTH];
    logic [OAW-1:0] owr_ptr_reg;
    logic [OAW-1:0] ord_ptr_reg;
    logic [OAW:0]   ocount_reg;
    logic [1:0]     n_push;
    logic           do_out;
    out_word_t      head;

    assign q_ready = (ocount_reg <= (OAW+1)'(ODEPTH - 2));
    assign do_step = q_valid && q_ready;

    always_comb begin
        x          = '0;
        x.st       = st_reg;
        eop_status = ST_OK;
        crc_chk    = '0;
        if (x.st.err == ST_OK) begin
            unique case (q_item.cls)
                CLS_SHORT: begin
                    x.st.level = ~x.st.level;
                    x = take_hb(x, x.st.level);
                end
                CLS_LONG: begin
                    x.st.level = ~x.st.level;
                    x = take_hb(x, x.st.level);
                    x = take_hb(x, x.st.level);
                end
                default: begin
                    x.st.err = ST_BAD_WIDTH;
                end
            endcase
        end
        if (q_item.last && x.st.err == ST_OK && !x.st.phase[0]) begin
            x = take_hb(x, 1'b1);
        end
        crc_mid = x.crc_upd ? crc_byte(crc_reg, x.crc_in) : crc_reg;
        crc_chk = crc_mid;
        if (x.st.count[0] == 1'b0 && x.st.count >= CNT_W'(4)) begin
            crc_chk = crc_byte(crc_mid, x.st.r2);
        end
        eop_status = x.st.err;
        if (x.st.err == ST_OK) begin
            if (!x.st.sync || x.st.phase != 4'd1 || x.st.count < CNT_W'(2)) begin
                eop_status = ST_BAD_LEN;
            end else if (crc_chk != {x.st.r1, x.st.r0}) begin
                eop_status = ST_BAD_CRC;
            end
        end

        byte_word.kind    = 1'b0;
        byte_word.data    = x.ebyte;
        byte_word.status  = x.estat;
        byte_word.total   = x.ecount;
        byte_word.run_end = ~q_item.last;
        stat_word.kind    = 1'b1;
        stat_word.data    = '0;
        stat_word.status  = eop_status;
        stat_word.total   = x.st.count;
        stat_word.run_end = 1'b1;

        if (q_item.last) begin
            st_new  = DEC_RESET;
            crc_new = CRC_INIT;
        end else begin
            st_new  = x.st;
            crc_new = crc_mid;
        end
        n_push = do_step ? ({1'b0, x.emit} + {1'b0, q_item.last}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= DEC_RESET;
            crc_reg <= CRC_INIT;
        end else if (do_step) begin
            st_reg  <= st_new;
            crc_reg <= crc_new;
        end
    end

    assign head     = omem[ord_ptr_reg];
    assign m_tvalid = (ocount_reg != '0);
    assign m_tdata  = {3'b000, head.total, head.status, head.data};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.run_end;
    assign do_out   = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            omem[owr_ptr_reg] <= x.emit ? byte_word : stat_word;
        end
        if (n_push == 2'd2) begin
            omem[owr_ptr_reg + 1'b1] <= stat_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end else begin
            owr_ptr_reg <= owr_ptr_reg + OAW'(n_push);
            if (do_out) begin
                ord_ptr_reg <= ord_ptr_reg + 1'b1;
            end
            ocount_reg <= ocount_reg + (OAW+1)'(n_push) - (OAW+1)'(do_out);
        end
    end

endmodule

FILE: hw/rtl/manchester_pulse_decoder_crc_core.sv
// ----------------------------------------------------------------------------
// Manchester pulse decoder with CRC-16 check
// Decodes pulse durations into bytes and ends each packet with a status word.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata (low bit up)                         tuser  tlast
// s_       in         duration[7:0]                              -      final_pulse
// m_       out        data_byte[7:0] status[10:8] total[20:11]   kind   run_end
//
// One pulse word is taken per cycle while s_tready is high; a word is written
// into the four-entry queue, read from there by the decoder, and its results
// leave through a four-entry output queue, one word per cycle while m_tready is
// high. The final pulse of a packet can yield a byte word and a status word.
// Reset is synchronous, active low; it restores the default window registers.
// A stalled m_ side fills the output queue, then the item queue, then drops
// s_tready.
// ----------------------------------------------------------------------------
module manchester_pulse_decoder_crc_core import mpdc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // duration[7:0]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // data_byte[7:0], status[10:8], total_bytes[20:11]
    output logic                 m_tuser,   // kind[0]
    output logic                 m_tlast
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    mpdc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    mpdc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    mpdc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/mpdc_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the result channel of the pulse decoder.
// ----------------------------------------------------------------------------
module mpdc_checker import mpdc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status word is not the last word of its pulse");

    a_status_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("status word carries data");

    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[10:8] == ST_OK || m_tdata[10:8] == ST_OVERFLOW)
        else $error("data word with an impossible status");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[10:8] <= ST_BAD_CRC)
        else $error("status code out of range");

endmodule

bind manchester_pulse_decoder_crc_core mpdc_checker u_mpdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: sim/mpdc_decode_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Manchester pulse decoder checker
// Watches the pulse and result channels of the decoder and the register write
// port. Every accepted pulse word runs through a local decoder model that
// tracks line level, half-bit phase, byte assembly, the running CRC-16 and the
// first error of the packet. The model queues the result words that the pulse
// must produce. Every accepted result word is compared field by field with the
// oldest queued word.
// ----------------------------------------------------------------------------
module mpdc_decode_check import mpdc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // duration[7:0]
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,   // data_byte[7:0], status[10:8], total_bytes[20:11]
    input  logic                 m_tuser,   // kind[0]
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   words_left,
    output int                   words_checked,
    output int                   clean_packets
);

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    logic [7:0]       win [4];
    logic             level;
    logic [3:0]       phase;
    logic             synced;
    logic             held;
    logic [7:0]       shreg;
    logic [CNT_W-1:0] nbytes;
    logic [15:0]      crc;
    logic [7:0]       hist [3];
    logic [2:0]       err;

    out_word_t step_words [2];
    int        step_n;
    out_word_t expected_words [$];

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        int i;
        r = c;
        for (i = 7; i >= 0; i--) begin
            r = {r[14:0], 1'b0} ^ ((r[15] ^ b[i]) ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic clear_packet_state();
        level   = 1'b1;
        phase   = '0;
        synced  = 1'b0;
        held    = 1'b0;
        shreg   = '0;
        nbytes  = '0;
        crc     = CRC_INIT;
        hist[0] = '0;
        hist[1] = '0;
        hist[2] = '0;
        err     = ST_OK;
    endtask

    task automatic note_word(input logic kind_v, input logic [7:0] byte_v, input logic [2:0] st);
        if (step_n < 2) begin
            step_words[step_n] = '{kind_v, byte_v, st, nbytes, 1'b0};
            step_n++;
        end
    endtask

    task automatic take_half(input logic h);
        logic b;
        if (err == ST_OK) begin
            if (!synced) begin
                synced = 1'b1;
            end else if (phase[0]) begin
                held = h;
            end else begin
                b = (held != h) ? held : 1'b0;
                shreg = {shreg[6:0], b};
                if (phase == 4'd0) begin
                    if (nbytes >= 3) crc = crc_next(crc, hist[2]);
                    hist[2] = hist[1];
                    hist[1] = hist[0];
                    hist[0] = shreg;
                    nbytes = nbytes + 1'b1;
                    if (nbytes >= MAX_BYTES) err = ST_OVERFLOW;
                    note_word(KIND_BYTE, shreg, err);
                    shreg = '0;
                end
            end
            phase = phase + 4'd1;
        end
    endtask

    task automatic decode_pulse(input logic [7:0] dur, input logic last);
        logic [15:0] c;
        int k;
        step_n = 0;
        if (err == ST_OK) begin
            if (dur >= win[REG_SHORT_MIN] && dur < win[REG_SHORT_LIMIT]) begin
                level = ~level;
                take_half(level);
            end else if (dur >= win[REG_LONG_MIN] && dur < win[REG_LONG_LIMIT]) begin
                level = ~level;
                take_half(level);
                take_half(level);
            end else begin
                err = ST_BAD_WIDTH;
            end
        end
        if (last) begin
            if (err == ST_OK && !phase[0]) take_half(1'b1);
            if (err == ST_OK) begin
                if (!synced || phase != 4'd1 || nbytes < 2) begin
                    err = ST_BAD_LEN;
                end else begin
                    c = crc;
                    if (!nbytes[0] && nbytes >= 4) c = crc_next(c, hist[2]);
                    if (c != {hist[1], hist[0]}) err = ST_BAD_CRC;
                end
            end
            if (err == ST_OK) clean_packets++;
            note_word(KIND_STATUS, 8'h00, err);
            clear_packet_state();
        end
        for (k = 0; k < step_n; k++) begin
            if (k == step_n - 1) step_words[k].run_end = 1'b1;
            expected_words.push_back(step_words[k]);
        end
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_word_t want;
        if (!aresetn) begin
            win[REG_SHORT_MIN]   = 8'd60;
            win[REG_SHORT_LIMIT] = 8'd115;
            win[REG_LONG_MIN]    = 8'd140;
            win[REG_LONG_LIMIT]  = 8'd200;
            clear_packet_state();
            expected_words.delete();
        end else begin
            if (cfg_wr_en) win[cfg_index] = cfg_wdata;
            if (s_tvalid && s_tready) decode_pulse(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                words_checked++;
                if (expected_words.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word, expected none, got tdata %h kind %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_words.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("data_byte", want.data, m_tdata[7:0]);
                    check_field("status", want.status, m_tdata[10:8]);
                    check_field("total_bytes", want.total, m_tdata[20:11]);
                    check_field("run_end", want.run_end, m_tlast);
                end
            end
        end
        words_left = expected_words.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Manchester pulse decoder testbench
// Drives pulse durations into the decoder: boundary widths first, then a
// packet long enough to overflow, then random packets under several window
// settings. Under disjoint windows most packets are well-formed Manchester
// frames with a correct CRC-16; the rest have a bad checksum, a wrong half-bit
// count, too few bytes, a bad width or random noise. Both channels idle in
// random bursts, and once the result side holds off long enough to stall the
// pulse side. The checker module predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    import mpdc_pkg::*;

    localparam int LIMIT        = 1_000_000;
    localparam int SETTLE       = 24;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int OVF_PULSES   = 4540;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int chk_fails;
    int chk_left;
    int chk_words;
    int chk_clean;

    int cycles  = 0;
    int sent    = 0;
    int packets = 0;
    bit quiet   = 1'b0;
    bit hold_req = 1'b0;
    bit rx_calm = 1'b0;

    logic [7:0] win [4];
    logic [7:0] plan [PHASES][4];
    logic [7:0] frame [$];
    logic [7:0] pulses [$];

    always #2 aclk = ~aclk;

    manchester_pulse_decoder_crc_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    mpdc_decode_check decode_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (chk_fails),
        .words_left    (chk_left),
        .words_checked (chk_words),
        .clean_packets (chk_clean)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin : receiver
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (cycles % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (!quiet && !rx_calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] pick_dur(input bit long_p);
        if (long_p) return 8'($urandom_range(win[REG_LONG_MIN], win[REG_LONG_LIMIT] - 1));
        return 8'($urandom_range(win[REG_SHORT_MIN], win[REG_SHORT_LIMIT] - 1));
    endfunction

    task automatic send_packet(input bit gappy);
        int k;
        for (k = 0; k < pulses.size(); k++) begin
            if (gappy && $urandom_range(0, 5) == 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge aclk);
            end
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tdata  <= pulses[k];
            s_tlast  <= (k == pulses.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sent++;
        end
        packets++;
    endtask

    // Well-formed frames carry a sync half-bit 0 and then each bit as the pair
    // (bit, not bit); runs of two equal half-bits become long pulses.
    task automatic send_random_packet(input bit coded);
        int pick, n, k, b, trim, i;
        logic [15:0] c;
        bit hb [$];
        pick = coded ? $urandom_range(0, 99) : 99;
        pulses.delete();
        if (pick >= 95) begin
            repeat ($urandom_range(1, 24)) pulses.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (pick >= 91) n = $urandom_range(0, 1);
            else if ($urandom_range(0, 15) == 0) n = $urandom_range(13, 40);
            else n = $urandom_range(2, 12);
            frame.delete();
            c = CRC_INIT;
            for (k = 0; k < n; k++) frame.push_back(8'($urandom_range(0, 255)));
            if (n >= 2) begin
                for (k = 0; k < ((n - 2) & ~1); k++) begin
                    for (b = 7; b >= 0; b--) begin
                        c = {c[14:0], 1'b0} ^ ((c[15] ^ frame[k][b]) ? CRC_POLY : 16'h0000);
                    end
                end
                frame[n - 2] = c[15:8];
                frame[n - 1] = c[7:0];
            end
            if (pick >= 65 && pick < 75 && n > 0) begin
                k = $urandom_range(0, n - 1);
                frame[k] = frame[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            hb.push_back(1'b0);
            for (k = 0; k < n; k++) begin
                for (b = 7; b >= 0; b--) begin
                    hb.push_back(frame[k][b]);
                    hb.push_back(!frame[k][b]);
                end
            end
            if (pick >= 75 && pick < 83) trim = $urandom_range(1, 5);
            else trim = (hb[hb.size() - 1] && $urandom_range(0, 1) == 1) ? 1 : 0;
            repeat (trim) if (hb.size() > 1) void'(hb.pop_back());
            i = 0;
            while (i < hb.size()) begin
                if (i + 1 < hb.size() && hb[i + 1] == hb[i]) begin
                    pulses.push_back(pick_dur(1'b1));
                    i += 2;
                end else begin
                    pulses.push_back(pick_dur(1'b0));
                    i += 1;
                end
            end
            if (pick >= 83 && pick < 91) begin
                k = $urandom_range(0, pulses.size() - 1);
                i = $urandom_range(0, 255);
                while ((i >= win[REG_SHORT_MIN] && i < win[REG_SHORT_LIMIT]) ||
                       (i >= win[REG_LONG_MIN] && i < win[REG_LONG_LIMIT]))
                    i = (i + 1) % 256;
                pulses[k] = 8'(i);
            end
        end
        send_packet(!quiet && $urandom_range(0, 3) != 0);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chk_left != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        win[idx] = val;
    endtask

    initial begin : stimulus
        logic [7:0] boundary_durs [10];
        int p, k, phase_start;
        bit coded;

        plan[0] = '{8'd60,  8'd115, 8'd140, 8'd200};
        plan[1] = '{8'd0,   8'd128, 8'd128, 8'd255};
        plan[2] = '{8'd1,   8'd2,   8'd2,   8'd3};
        plan[3] = '{8'd200, 8'd255, 8'd10,  8'd60};
        plan[4] = '{8'd255, 8'd100, 8'd0,   8'd255};
        plan[5] = '{8'd0,   8'd255, 8'd255, 8'd0};
        plan[6] = '{8'd60,  8'd115, 8'd140, 8'd200};
        boundary_durs = '{8'd60, 8'd59, 8'd114, 8'd115, 8'd139,
                          8'd140, 8'd199, 8'd200, 8'd0, 8'd255};
        for (k = 0; k < 4; k++) win[k] = plan[0][k];

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < 10; k++) begin
            pulses = '{boundary_durs[k]};
            send_packet(1'b1);
        end
        pulses = '{8'd60, 8'd0, 8'd140};
        send_packet(1'b0);

        pulses.delete();
        repeat (OVF_PULSES) pulses.push_back(pick_dur(1'b1));
        send_packet(1'b1);

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                write_reg(REG_SHORT_MIN,   plan[p][REG_SHORT_MIN]);
                write_reg(REG_SHORT_LIMIT, plan[p][REG_SHORT_LIMIT]);
                write_reg(REG_LONG_MIN,    plan[p][REG_LONG_MIN]);
                write_reg(REG_LONG_LIMIT,  plan[p][REG_LONG_LIMIT]);
                @(negedge aclk);
                cfg_wr_en <= 1'b0;
            end
            quiet = (p == PHASES - 1);
            if (p == 1) hold_req = 1'b1;
            coded = win[REG_SHORT_MIN] < win[REG_SHORT_LIMIT] &&
                    win[REG_LONG_MIN] < win[REG_LONG_LIMIT] &&
                    (win[REG_SHORT_LIMIT] <= win[REG_LONG_MIN] ||
                     win[REG_LONG_LIMIT] <= win[REG_SHORT_MIN]);
            phase_start = sent;
            while (sent - phase_start < RANDOM_ITEMS / PHASES) send_random_packet(coded);
        end
        settle();

        $display("Covered %0d pulse words in %0d packets under %0d window settings, overflow included.",
                 sent, packets, PHASES);
        $display("Checked %0d result words; %0d packets closed with a clean status.",
                 chk_words, chk_clean);
        if (chk_fails == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
